[sv/cdt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types, widths, codes and constants of the chunk dispatch table.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int unsigned MAX_ENTRIES  = 1024;

    localparam int unsigned ROW_BITS     = 32;
    localparam int unsigned COL_W        = $clog2(ROW_BITS);

    localparam int unsigned FUNC_W       = 3;
    localparam int unsigned CHUNK_ID_W   = 10;
    localparam int unsigned TOTAL_W      = 40;
    localparam int unsigned CHUNK_SIZE_W = 32;
    localparam int unsigned COUNT_W      = 16;
    localparam int unsigned THR_W        = 8;

    localparam logic [CHUNK_SIZE_W-1:0] SIZE_CAP       = 32'h0100_0000;
    localparam logic [CHUNK_SIZE_W-1:0] SIZE_FLOOR     = 32'h0008_0000;
    localparam logic [CHUNK_SIZE_W-1:0] CHUNK_SIZE_RST = 32'h0010_0000;
    localparam logic [THR_W-1:0]        THR_RST        = 8'd3;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_TOTAL = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHUNK = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_THR   = 2'd2;

    localparam logic [FUNC_W-1:0] FN_DISPATCH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SUCCESS  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FAILED   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_COMPLETE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUERY    = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [CHUNK_ID_W-1:0] chunk_ref;
    } cdt_in_t;

    typedef struct packed {
        logic                    ok;
        logic [CHUNK_ID_W-1:0]   chunk_index;
        logic [TOTAL_W-1:0]      range_start;
        logic [TOTAL_W-1:0]      range_end;
        logic [COUNT_W-1:0]      done_count;
        logic [CHUNK_SIZE_W-1:0] adaptive_size;
    } cdt_out_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]      total_bytes;
        logic [CHUNK_SIZE_W-1:0] chunk_size;
        logic [THR_W-1:0]        run_limit;
    } cdt_cfg_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] done;
        logic [ROW_BITS-1:0] claimed;
    } cdt_row_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic row_inc;
        logic scan;
        logic mul;
        logic add;
        logic exec;
    } cdt_cmd_t;

    typedef struct packed {
        logic last_row;
        logic found;
        logic new_disp;
    } cdt_sts_t;

endpackage
`default_nettype wire

[sv/cdt_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cdt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[sv/cdt_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_regs
// APB register file: total size, chunk size and streak threshold.
// ----------------------------------------------------------------------------
module cdt_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cdt_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [cdt_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cdt_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output cdt_pkg::cdt_cfg_t                   cfg,
    output logic                                size_load
);
    import cdt_pkg::*;

    logic [TOTAL_W-1:0]      total_reg;
    logic [CHUNK_SIZE_W-1:0] chunk_reg;
    logic [THR_W-1:0]        thr_reg;
    logic                    size_load_reg;
    logic                    wr;
    logic [REG_IDX_W-1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:3];

    // pulses the cycle after a chunk size write, when the new value is visible
    assign size_load = size_load_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            chunk_reg     <= CHUNK_SIZE_RST;
            thr_reg       <= THR_RST;
            size_load_reg <= 1'b0;
        end
        else
        begin
            size_load_reg <= wr && (reg_idx == REG_CHUNK);
            if (wr)
            begin
                unique case (reg_idx)
                    REG_TOTAL: total_reg <= pwdata[TOTAL_W-1:0];
                    REG_CHUNK: chunk_reg <= pwdata[CHUNK_SIZE_W-1:0];
                    REG_THR:   thr_reg   <= pwdata[THR_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TOTAL: prdata = APB_DATA_W'(total_reg);
            REG_CHUNK: prdata = APB_DATA_W'(chunk_reg);
            REG_THR:   prdata = APB_DATA_W'(thr_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg.total_bytes = total_reg;
    assign cfg.chunk_size  = chunk_reg;
    assign cfg.run_limit   = thr_reg;

endmodule
`default_nettype wire

[sv/cdt_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_ctrl
// Sequencer: flag clear sweep, row scan, multiply, add and commit steps.
// ----------------------------------------------------------------------------
module cdt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  cdt_pkg::cdt_sts_t sts,
    output cdt_pkg::cdt_cmd_t cmd
);
    import cdt_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CHK = 3'd3;
    localparam logic [2:0] S_RD       = 3'd4;
    localparam logic [2:0] S_MUL      = 3'd5;
    localparam logic [2:0] S_ADD      = 3'd6;
    localparam logic [2:0] S_FIN      = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.last_row)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.new_disp ? S_SCAN_RD : S_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan = 1'b1;
                if (sts.found || sts.last_row)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[sv/cdt_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_dp
// Datapath: flag RAM, find-first, range multiply, counters, adaptive size.
// ----------------------------------------------------------------------------
module cdt_dp #(
    parameter int unsigned MAX_ENTRIES = cdt_pkg::MAX_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cdt_pkg::cdt_cmd_t cmd,
    output cdt_pkg::cdt_sts_t sts,
    input  cdt_pkg::cdt_in_t  in_data,
    input  cdt_pkg::cdt_cfg_t cfg,
    input  logic              size_load,
    output cdt_pkg::cdt_out_t out_data
);
    import cdt_pkg::*;

    localparam int unsigned ROWS   = (MAX_ENTRIES + ROW_BITS - 1) / ROW_BITS;
    localparam int unsigned RAW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned IW     = ($clog2(MAX_ENTRIES) > CHUNK_ID_W) ?
                                     $clog2(MAX_ENTRIES) : CHUNK_ID_W;
    localparam int unsigned PROD_W = IW + CHUNK_SIZE_W;
    localparam int unsigned END_W  = PROD_W + 1;

    logic [RAW-1:0]          row_ptr_reg;
    logic [FUNC_W-1:0]       func_reg;
    logic [CHUNK_ID_W-1:0]   id_reg;
    logic [IW-1:0]           idx_reg;
    logic                    hit_reg;
    cdt_row_t                row_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    exists_reg;
    logic [END_W-1:0]        end_raw_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;
    logic [CHUNK_SIZE_W-1:0] size_reg;
    logic [CHUNK_SIZE_W-1:0] size_next;
    logic [THR_W-1:0]        run_reg;
    logic [THR_W-1:0]        run_next;
    cdt_out_t                out_reg;
    cdt_out_t                out_next;

    logic [$bits(cdt_row_t)-1:0] rd_data;
    cdt_row_t                    rd_row;
    cdt_row_t                    row_new;
    logic                        ram_we;
    logic [ROW_BITS-1:0]         free;
    logic                        found;
    logic [COL_W-1:0]            col_found;
    logic [IW-1:0]               idx_in;
    logic [IW-1:0]               row_sel;
    logic [COL_W-1:0]            col;
    logic                        done_bit;
    logic [THR_W-1:0]            run_inc;
    logic [CHUNK_SIZE_W:0]       dbl;
    logic [CHUNK_SIZE_W-1:0]     half;
    logic [CHUNK_SIZE_W-1:0]     size_dbl;
    logic [CHUNK_SIZE_W-1:0]     size_half;
    logic [COUNT_W-1:0]          count_sat;
    logic [TOTAL_W-1:0]          total_m1;
    logic [TOTAL_W-1:0]          end_cap;
    logic                        id_op;
    logic                        ranged;

    cdt_ram #(
        .WIDTH($bits(cdt_row_t)),
        .DEPTH(ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_ptr_reg),
        .wdata (cmd.clear ? '0 : row_new),
        .raddr (row_ptr_reg),
        .rdata (rd_data)
    );

    assign rd_row = cdt_row_t'(rd_data);
    assign free   = ~(rd_row.done | rd_row.claimed);

    always_comb
    begin
        found     = 1'b0;
        col_found = '0;
        for (int c = ROW_BITS - 1; c >= 0; c--)
        begin
            if (free[c])
            begin
                found     = 1'b1;
                col_found = COL_W'(c);
            end
        end
    end

    assign idx_in  = IW'(in_data.chunk_ref);
    assign row_sel = idx_in >> COL_W;

    assign sts.last_row = (row_ptr_reg == RAW'(ROWS - 1));
    assign sts.found    = found;
    assign sts.new_disp = (in_data.func == FN_DISPATCH);

    // row pointer serves the clear sweep, the scan and single-chunk requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ptr_reg <= '0;
        end
        else if (cmd.accept)
        begin
            row_ptr_reg <= (in_data.func == FN_DISPATCH) ? '0 : row_sel[RAW-1:0];
        end
        else if (cmd.row_inc)
        begin
            row_ptr_reg <= row_ptr_reg + RAW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= in_data.func;
            id_reg   <= in_data.chunk_ref;
            idx_reg  <= idx_in;
            hit_reg  <= (in_data.func == FN_SUCCESS) || (in_data.func == FN_FAILED) ||
                        (in_data.func == FN_COMPLETE) || (in_data.func == FN_QUERY);
        end
        else if (cmd.scan && found)
        begin
            idx_reg <= (IW'(row_ptr_reg) << COL_W) | IW'(col_found);
            hit_reg <= 1'b1;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(idx_reg) * PROD_W'(cfg.chunk_size);
            row_reg  <= rd_row;
        end
        if (cmd.add)
        begin
            exists_reg  <= hit_reg &&
                           ({1'b0, idx_reg} < (IW + 1)'(MAX_ENTRIES)) &&
                           (cfg.chunk_size != '0) &&
                           (prod_reg < PROD_W'(cfg.total_bytes));
            end_raw_reg <= END_W'(prod_reg) + END_W'(cfg.chunk_size) - END_W'(1);
        end
        if (cmd.exec)
        begin
            out_reg <= out_next;
        end
    end

    assign col      = idx_reg[COL_W-1:0];
    assign done_bit = row_reg.done[col];
    assign run_inc  = run_reg + THR_W'(1);
    assign dbl      = {size_reg, 1'b0};
    assign half     = size_reg >> 1;
    assign size_dbl = (dbl > (CHUNK_SIZE_W + 1)'(SIZE_CAP)) ? SIZE_CAP :
                      dbl[CHUNK_SIZE_W-1:0];
    assign size_half = (half < SIZE_FLOOR) ? SIZE_FLOOR : half;
    assign count_sat = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);

    always_comb
    begin
        row_new    = row_reg;
        count_next = count_reg;
        size_next  = size_reg;
        run_next   = run_reg;
        if (size_load)
        begin
            size_next = cfg.chunk_size;
        end
        if (cmd.exec && exists_reg)
        begin
            unique case (func_reg)
                FN_DISPATCH:
                begin
                    row_new.claimed[col] = 1'b1;
                end
                FN_SUCCESS:
                begin
                    row_new.done[col]    = 1'b1;
                    row_new.claimed[col] = 1'b0;
                    count_next           = count_sat;
                    if (run_inc >= cfg.run_limit)
                    begin
                        size_next = size_dbl;
                        run_next  = '0;
                    end
                    else
                    begin
                        run_next = run_inc;
                    end
                end
                FN_FAILED:
                begin
                    row_new.claimed[col] = 1'b0;
                    run_next             = '0;
                    size_next            = size_half;
                end
                FN_COMPLETE:
                begin
                    if (!done_bit)
                    begin
                        row_new.done[col]    = 1'b1;
                        row_new.claimed[col] = 1'b0;
                        count_next           = count_sat;
                    end
                end
                default: ;
            endcase
        end
    end

    assign ram_we = cmd.clear || (cmd.exec && exists_reg && (func_reg <= FN_COMPLETE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            size_reg  <= CHUNK_SIZE_RST;
            run_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            size_reg  <= size_next;
            run_reg   <= run_next;
        end
    end

    assign total_m1 = cfg.total_bytes - TOTAL_W'(1);
    assign end_cap  = (end_raw_reg > END_W'(total_m1)) ? total_m1 :
                      end_raw_reg[TOTAL_W-1:0];
    assign id_op    = (func_reg == FN_SUCCESS) || (func_reg == FN_FAILED) ||
                      (func_reg == FN_COMPLETE) || (func_reg == FN_QUERY);
    assign ranged   = exists_reg && ((func_reg == FN_DISPATCH) || (func_reg == FN_QUERY));

    always_comb
    begin
        out_next.ok            = exists_reg;
        out_next.chunk_index   = id_op ? id_reg :
                                 (exists_reg ? idx_reg[CHUNK_ID_W-1:0] : '0);
        out_next.range_start   = ranged ? prod_reg[TOTAL_W-1:0] : '0;
        out_next.range_end     = ranged ? end_cap : '0;
        out_next.done_count    = count_next;
        out_next.adaptive_size = size_next;
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

[sv/chunk_dispatch_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_dispatch_table
// Byte-range chunk table with dispatch, success/failure/completion marking,
// range query and an adaptive chunk size report.
// ----------------------------------------------------------------------------
// One request is in work at a time. Mark and query requests go through the
// steps accept, flag row read, range multiply, end add and commit before the
// next acceptance. Dispatch scans the flag RAM one row of 32 chunks at a
// time, with a read step and a check step per row, up to the first row with
// a free chunk, at most ceil(MAX_ENTRIES/32) rows, then multiplies, adds and
// commits. After reset the flag RAM is cleared one row a cycle over
// ceil(MAX_ENTRIES/32) rows (32 at the default depth), and no request is
// accepted until it is done; register writes are taken throughout. A
// finished result waits in the output register while the next request is
// accepted; the commit step stalls only if that register is still occupied.
module chunk_dispatch_table #(
    parameter int unsigned MAX_ENTRIES = cdt_pkg::MAX_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cdt_pkg::cdt_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cdt_pkg::cdt_out_t              out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cdt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cdt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cdt_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import cdt_pkg::*;

    cdt_cfg_t cfg;
    logic     size_load;
    cdt_cmd_t cmd;
    cdt_sts_t sts;

    cdt_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .size_load (size_load)
    );

    cdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cdt_dp #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg       (cfg),
        .size_load (size_load),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

[sv/cdt_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_checker
// Port-level checks of the chunk dispatch table, bound to the top level.
// ----------------------------------------------------------------------------
module cdt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input cdt_pkg::cdt_out_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in work");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ok |->
            out_data.range_start == '0 && out_data.range_end == '0)
        else $error("range reported on a failed request");

    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.ok |-> out_data.range_start <= out_data.range_end)
        else $error("range end before range start");

endmodule

bind chunk_dispatch_table cdt_checker u_cdt_checker (.*);
`default_nettype wire
